[rtl/adsr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared constants, codes and controller/datapath interface types for the
// polyphonic linear ADSR envelope generator.
// ----------------------------------------------------------------------------
package adsr_pkg;

   // Defaults for the top-level parameters
   localparam int VOICES_DEF      = 16;
   localparam int SAMPLE_RATE_DEF = 48000;

   // Field and register widths
   localparam int VOICE_W    = 4;
   localparam int MS_W       = 16;
   localparam int SUS_W      = 24;
   localparam int LVL_W      = 32;
   localparam int OUT_LVL_W  = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 32;

   // Durations are given in milliseconds
   localparam int MS_PER_S = 1000;

   // Q1.31 full scale and Q1.23 sustain ceiling
   localparam logic [LVL_W-1:0] FULL_Q31 = 32'h8000_0000;
   localparam logic [SUS_W-1:0] SUS_MAX  = 24'd8388608;

   // Per-voice envelope phase
   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_ATTACK  = 3'd1,
      PH_DECAY   = 3'd2,
      PH_SUSTAIN = 3'd3,
      PH_RELEASE = 3'd4
   } phase_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ATTACK  = 2'd0,
      CSR_DECAY   = 2'd1,
      CSR_SUSTAIN = 2'd2,
      CSR_RELEASE = 2'd3
   } csr_index_type;

   // Which step the datapath is working out
   typedef enum logic [1:0] {
      KIND_ATTACK  = 2'd0,
      KIND_DECAY   = 2'd1,
      KIND_RELEASE = 2'd2
   } step_kind_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_EVAL   = 3'd1,
      ST_MUL    = 3'd2,
      ST_NSTART = 3'd3,
      ST_NWAIT  = 3'd4,
      ST_SSTART = 3'd5,
      ST_SWAIT  = 3'd6,
      ST_COMMIT = 3'd7
   } ctrl_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic          item_load;
      logic          mul_en;
      logic          div_start;
      logic          recip_en;
      logic          capture_n;
      logic          store_step;
      step_kind_type step_kind;
      logic          commit;
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic rise;
      logic fall;
      logic div_done;
   } dpath_status_type;

endpackage
`default_nettype wire

[rtl/adsr_envelope_generator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// adsr_envelope_generator
// Polyphonic linear ADSR envelope generator, one level per voice sample tick.
// ----------------------------------------------------------------------------
// Each request is one sample tick of one voice and returns one response with
// that voice and its envelope level in Q1.23. A tick without a gate edge goes
// through accept, evaluate and commit. A gate edge first works out its steps:
// the tick count sample_rate * ms / 1000 comes from two small products and a
// reciprocal multiply by a constant, then the span is divided by it on one
// shared bit-serial divider of W = 32 bits. A falling gate needs one step, a
// rising gate two, attack and decay. A stalled response adds its stall to the
// commit state. The response register lets the next request in while the
// previous response waits. Voice state is held in flip-flops and cleared by
// reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module adsr_envelope_generator #(
   parameter int VOICES      = adsr_pkg::VOICES_DEF,
   parameter int SAMPLE_RATE = adsr_pkg::SAMPLE_RATE_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [3:0] voice, [4] gate_on, [7:5] zero
   input  wire logic [adsr_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [3:0] out_voice, [27:4] level, [31:28] zero
   output logic [adsr_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   input  wire logic                                csr_we,
   input  wire logic [adsr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [adsr_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   adsr_pkg::ctrl_cmd_type     cmd;
   adsr_pkg::dpath_status_type status;

   adsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   adsr_dpath #(
      .VOICES      (VOICES),
      .SAMPLE_RATE (SAMPLE_RATE)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_voice (req_tdata[adsr_pkg::VOICE_W-1:0]),
      .req_gate  (req_tdata[adsr_pkg::VOICE_W]),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_tdata)
   );

endmodule
`default_nettype wire

[rtl/adsr_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// adsr_div
// Restoring radix-2 unsigned divider, one quotient bit per cycle. When the last
// quotient bit is in, it pulses done for one cycle with the quotient held.
// ----------------------------------------------------------------------------
module adsr_div #(
   parameter int W = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [W-1:0] dividend,
   input  wire logic [W-1:0] divisor,
   output logic              done,
   output logic [W-1:0]      quotient
);

   localparam int CNT_W = $clog2(W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     dvs_ff, dvs_in;
   logic [W:0]       rem_sh;
   logic [W:0]       rem_sub;

   // One shift-and-subtract step
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[W-1]};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(W);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = rem_sub[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

[rtl/adsr_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// adsr_ctrl
// Sequencer for the envelope generator: accepts a request, runs the step
// divisions that a gate edge needs, then commits the voice update into the
// response register.
// ----------------------------------------------------------------------------
module adsr_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   input  wire adsr_pkg::dpath_status_type status,
   output adsr_pkg::ctrl_cmd_type         cmd
);

   adsr_pkg::ctrl_state_type state_ff, state_in;
   adsr_pkg::step_kind_type  kind_ff, kind_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.step_kind = kind_ff;
      unique case (state_ff)
         adsr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.item_load = 1'b1;
               state_in      = adsr_pkg::ST_EVAL;
            end
         end
         adsr_pkg::ST_EVAL: begin
            if (status.rise) begin
               kind_in  = adsr_pkg::KIND_ATTACK;
               state_in = adsr_pkg::ST_MUL;
            end else if (status.fall) begin
               kind_in  = adsr_pkg::KIND_RELEASE;
               state_in = adsr_pkg::ST_MUL;
            end else begin
               state_in = adsr_pkg::ST_COMMIT;
            end
         end
         adsr_pkg::ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = adsr_pkg::ST_NSTART;
         end
         // tick count: reciprocal product, then the sum
         adsr_pkg::ST_NSTART: begin
            cmd.recip_en = 1'b1;
            state_in     = adsr_pkg::ST_NWAIT;
         end
         adsr_pkg::ST_NWAIT: begin
            cmd.capture_n = 1'b1;
            state_in      = adsr_pkg::ST_SSTART;
         end
         adsr_pkg::ST_SSTART: begin
            cmd.div_start = 1'b1;
            state_in      = adsr_pkg::ST_SWAIT;
         end
         adsr_pkg::ST_SWAIT: begin
            if (status.div_done) begin
               cmd.store_step = 1'b1;
               // attack step is always followed by the decay step
               if (kind_ff == adsr_pkg::KIND_ATTACK) begin
                  kind_in  = adsr_pkg::KIND_DECAY;
                  state_in = adsr_pkg::ST_MUL;
               end else begin
                  state_in = adsr_pkg::ST_COMMIT;
               end
            end
         end
         adsr_pkg::ST_COMMIT: begin
            // wait for the response register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = adsr_pkg::ST_IDLE;
            end
         end
         default: state_in = adsr_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= adsr_pkg::ST_IDLE;
         kind_ff      <= adsr_pkg::KIND_ATTACK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

[rtl/adsr_dpath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// adsr_dpath
// Datapath: configuration registers, per-voice state, tick-count multipliers,
// shared divider for step computation, phase update and response register.
// ----------------------------------------------------------------------------
module adsr_dpath #(
   parameter int VOICES      = adsr_pkg::VOICES_DEF,
   parameter int SAMPLE_RATE = adsr_pkg::SAMPLE_RATE_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [adsr_pkg::VOICE_W-1:0]        req_voice,
   input  wire logic                                req_gate,
   input  wire logic                                csr_we,
   input  wire logic [adsr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [adsr_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire adsr_pkg::ctrl_cmd_type              cmd,
   output adsr_pkg::dpath_status_type               status,
   output logic [adsr_pkg::RSP_DATA_W-1:0]          rsp_data
);

   localparam int IDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int LW     = adsr_pkg::LVL_W;

   // ticks = RATE_Q * ms + (RATE_R * ms) / 1000, the last part by reciprocal
   localparam int RATE_Q   = SAMPLE_RATE / adsr_pkg::MS_PER_S;
   localparam int RATE_R   = SAMPLE_RATE % adsr_pkg::MS_PER_S;
   localparam int RQ_W     = $clog2(RATE_Q + 1);
   localparam int RR_W     = $clog2(adsr_pkg::MS_PER_S);
   localparam int BASE_W   = RQ_W + adsr_pkg::MS_W;
   localparam int FRAC_W   = RR_W + adsr_pkg::MS_W;
   localparam int RECIP_SH = FRAC_W + RR_W;
   localparam longint RECIP_M = ((longint'(1) << RECIP_SH) +
                                 longint'(adsr_pkg::MS_PER_S) - 1) /
                                longint'(adsr_pkg::MS_PER_S);
   localparam int RECIP_W  = $clog2(RECIP_M + 1);
   localparam int RPROD_W  = FRAC_W + RECIP_W;
   localparam int NFRAC_W  = RPROD_W - RECIP_SH;

   // Configuration registers
   logic [adsr_pkg::MS_W-1:0]  attack_ms_ff, decay_ms_ff, release_ms_ff;
   logic [adsr_pkg::SUS_W-1:0] sustain_ff;

   // Per-voice state
   logic [LW-1:0]       lvl_mem_ff   [VOICES];
   adsr_pkg::phase_type ph_mem_ff    [VOICES];
   logic                held_mem_ff  [VOICES];
   logic [LW-1:0]       rstep_mem_ff [VOICES];

   // Shared steps
   logic [LW-1:0] astep_ff, dstep_ff;

   // Latched item and its voice state
   logic [adsr_pkg::VOICE_W-1:0] voice_ff;
   logic                         gate_ff;
   logic                         inr_ff;
   logic                         held_ff;
   adsr_pkg::phase_type          ph_ff;
   logic [LW-1:0]                lvl_ff;
   logic [LW-1:0]                rstep_ff;

   // Step computation
   logic [BASE_W-1:0]  base_ff;
   logic [FRAC_W-1:0]  frac_ff;
   logic [RPROD_W-1:0] recip_prod;
   logic [NFRAC_W-1:0] nfrac_ff;
   logic [LW-1:0]      n_ff;
   logic [adsr_pkg::MS_W-1:0] ms_sel;
   logic [LW-1:0]      span_sel;
   logic               div_done;
   logic [LW-1:0]      div_q;
   logic [LW-1:0]      step_val;

   // Update
   logic [adsr_pkg::SUS_W-1:0] sus24;
   logic [LW-1:0]              sus;
   logic                       rd_inr;
   logic [IDX_W-1:0]           rd_idx, wr_idx;
   logic                       rise, fall;
   adsr_pkg::phase_type        ph_cur, ph_new;
   logic [LW:0]                acc_sum, dec_thr;
   logic [LW-1:0]              lvl_new;
   logic [adsr_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         attack_ms_ff  <= '0;
         decay_ms_ff   <= '0;
         sustain_ff    <= '0;
         release_ms_ff <= '0;
      end else if (csr_we) begin
         unique case (adsr_pkg::csr_index_type'(csr_index))
            adsr_pkg::CSR_ATTACK:  attack_ms_ff  <= csr_wdata[adsr_pkg::MS_W-1:0];
            adsr_pkg::CSR_DECAY:   decay_ms_ff   <= csr_wdata[adsr_pkg::MS_W-1:0];
            adsr_pkg::CSR_SUSTAIN: sustain_ff    <= csr_wdata;
            adsr_pkg::CSR_RELEASE: release_ms_ff <= csr_wdata[adsr_pkg::MS_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamped sustain target in Q1.31
   assign sus24 = (sustain_ff > adsr_pkg::SUS_MAX) ? adsr_pkg::SUS_MAX : sustain_ff;
   assign sus   = {sus24, 8'd0};

   // Voice index handling
   assign rd_inr = ({28'd0, req_voice} < 32'(VOICES));
   assign rd_idx = IDX_W'(req_voice);
   assign wr_idx = IDX_W'(voice_ff);

   // Latch the request and read its voice state
   always_ff @(posedge clock) begin
      if (cmd.item_load) begin
         voice_ff <= req_voice;
         gate_ff  <= req_gate;
         inr_ff   <= rd_inr;
         if (rd_inr) begin
            held_ff  <= held_mem_ff[rd_idx];
            ph_ff    <= ph_mem_ff[rd_idx];
            lvl_ff   <= lvl_mem_ff[rd_idx];
            rstep_ff <= rstep_mem_ff[rd_idx];
         end else begin
            held_ff  <= 1'b0;
            ph_ff    <= adsr_pkg::PH_IDLE;
            lvl_ff   <= '0;
            rstep_ff <= '0;
         end
      end else if (cmd.store_step && cmd.step_kind == adsr_pkg::KIND_RELEASE) begin
         rstep_ff <= step_val;
      end
   end

   assign rise = inr_ff & gate_ff & ~held_ff;
   assign fall = inr_ff & ~gate_ff & held_ff;

   // Duration and span selection
   always_comb begin
      case (cmd.step_kind)
         adsr_pkg::KIND_ATTACK: begin
            ms_sel   = attack_ms_ff;
            span_sel = adsr_pkg::FULL_Q31;
         end
         adsr_pkg::KIND_DECAY: begin
            ms_sel   = decay_ms_ff;
            span_sel = adsr_pkg::FULL_Q31 - sus;
         end
         default: begin
            ms_sel   = release_ms_ff;
            span_sel = lvl_ff;
         end
      endcase
   end

   // Tick count in registered steps: small products, reciprocal product, sum
   assign recip_prod = RPROD_W'(frac_ff) * RPROD_W'(RECIP_M);

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         base_ff <= BASE_W'(RATE_Q) * BASE_W'(ms_sel);
         frac_ff <= FRAC_W'(RATE_R) * FRAC_W'(ms_sel);
      end
      if (cmd.recip_en) begin
         nfrac_ff <= recip_prod[RPROD_W-1:RECIP_SH];
      end
      if (cmd.capture_n) begin
         n_ff <= LW'(base_ff) + LW'(nfrac_ff);
      end
   end

   // Step = span / ticks
   adsr_div #(
      .W (LW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (span_sel),
      .divisor  (n_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // Zero ticks jump to target; a non-zero span never gets a zero step
   always_comb begin
      if (n_ff == '0) begin
         step_val = adsr_pkg::FULL_Q31;
      end else if (div_q == '0 && span_sel != '0) begin
         step_val = LW'(1);
      end else begin
         step_val = div_q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         astep_ff <= '0;
         dstep_ff <= '0;
      end else if (cmd.store_step) begin
         if (cmd.step_kind == adsr_pkg::KIND_ATTACK) begin
            astep_ff <= step_val;
         end
         if (cmd.step_kind == adsr_pkg::KIND_DECAY) begin
            dstep_ff <= step_val;
         end
      end
   end

   // Phase and level update
   always_comb begin
      if (rise) begin
         ph_cur = adsr_pkg::PH_ATTACK;
      end else if (fall) begin
         ph_cur = adsr_pkg::PH_RELEASE;
      end else begin
         ph_cur = ph_ff;
      end
      acc_sum = {1'b0, lvl_ff} + {1'b0, astep_ff};
      dec_thr = {1'b0, sus} + {1'b0, dstep_ff};
      ph_new  = ph_cur;
      lvl_new = lvl_ff;
      case (ph_cur)
         adsr_pkg::PH_ATTACK: begin
            if (acc_sum >= {1'b0, adsr_pkg::FULL_Q31}) begin
               lvl_new = adsr_pkg::FULL_Q31;
               ph_new  = adsr_pkg::PH_DECAY;
            end else begin
               lvl_new = acc_sum[LW-1:0];
            end
         end
         adsr_pkg::PH_DECAY: begin
            if ({1'b0, lvl_ff} <= dec_thr) begin
               lvl_new = sus;
               ph_new  = adsr_pkg::PH_SUSTAIN;
            end else begin
               lvl_new = lvl_ff - dstep_ff;
            end
         end
         adsr_pkg::PH_SUSTAIN: lvl_new = sus;
         adsr_pkg::PH_RELEASE: begin
            if (lvl_ff <= rstep_ff) begin
               lvl_new = '0;
               ph_new  = adsr_pkg::PH_IDLE;
            end else begin
               lvl_new = lvl_ff - rstep_ff;
            end
         end
         adsr_pkg::PH_IDLE: lvl_new = '0;
         default: ;
      endcase
   end

   // Voice state write-back
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < VOICES; i++) begin
            lvl_mem_ff[i]   <= '0;
            ph_mem_ff[i]    <= adsr_pkg::PH_IDLE;
            held_mem_ff[i]  <= 1'b0;
            rstep_mem_ff[i] <= '0;
         end
      end else if (cmd.commit && inr_ff) begin
         lvl_mem_ff[wr_idx]   <= lvl_new;
         ph_mem_ff[wr_idx]    <= ph_new;
         held_mem_ff[wr_idx]  <= gate_ff;
         rstep_mem_ff[wr_idx] <= rstep_ff;
      end
   end

   // Response register: out_voice, then Q1.23 level
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data_ff <= {4'd0, (inr_ff ? lvl_new[LW-1:8] : 24'd0), voice_ff};
      end
   end

   assign rsp_data        = rsp_data_ff;
   assign status.rise     = rise;
   assign status.fall     = fall;
   assign status.div_done = div_done;

endmodule
`default_nettype wire

[rtl/adsr_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// adsr_checker
// Port-level checks for the envelope generator, bound to the top level.
// ----------------------------------------------------------------------------
module adsr_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [adsr_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // A stalled response holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // Level never exceeds full scale
   a_level_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[27:4] <= 24'd8388608)
      else $error("level above full scale");

   // One request at a time: ready drops after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // No response straight out of reset
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind adsr_envelope_generator adsr_checker u_adsr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the polyphonic linear ADSR envelope generator.
// A short table of directed ticks and register writes comes first. Rows with
// an obvious answer carry it. Every other row is checked against an
// in-bench envelope predictor. Seven random phases follow, each with its own
// register setting. Most ticks follow held/released gate patterns on a few
// busy voices, so that whole envelopes play out. Both stream sides stall at
// random, except in one phase where they run flat out.
// ----------------------------------------------------------------------------
module tb;
   import adsr_pkg::*;

   localparam int DIR_ROWS       = 31;
   localparam int PHASES         = 7;
   localparam int TICKS_PER_PASS = 100;
   localparam int STALL_PCT      = 36;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int N_VOICES       = VOICES_DEF;

   // One envelope sample as it leaves the block
   typedef struct packed {
      logic [VOICE_W-1:0]   voice;
      logic [OUT_LVL_W-1:0] level;
   } envelope_sample_type;

   // One row of the directed table: a register write or a voice tick
   typedef struct packed {
      logic                 is_csr;
      csr_index_type        idx;
      logic [CSR_DATA_W-1:0] value;
      logic [VOICE_W-1:0]   voice;
      logic                 gate;
      logic                 typed;
      logic [OUT_LVL_W-1:0] level;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Predictor copy of the registers and of the per-voice state
   logic [MS_W-1:0]  attack_ms_q, decay_ms_q, release_ms_q;
   logic [SUS_W-1:0] sustain_q;
   logic [LVL_W-1:0] env_level [N_VOICES];
   phase_type        env_phase [N_VOICES];
   logic             key_down [N_VOICES];
   logic [LVL_W-1:0] fade_step [N_VOICES];
   logic [LVL_W-1:0] climb_step, drop_step;

   envelope_sample_type pending_levels [$];
   plan_row_type        plan_rows [DIR_ROWS];

   // Random driving state
   bit          quiet = 1'b0;
   logic        gate_plan [N_VOICES];
   int unsigned gate_left [N_VOICES];
   int          mismatches = 0;
   int          idle_cycles = 0;

   adsr_envelope_generator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [3:0] voice, [4] gate_on, [7:5] zero
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [3:0] out_voice, [27:4] level, [31:28] zero
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // Step that covers span in ms milliseconds of ticks
   function automatic logic [63:0] ramp_step(input logic [63:0] span,
                                             input logic [MS_W-1:0] ms);
      logic [63:0] ticks;
      logic [63:0] st;
      ticks = (64'(SAMPLE_RATE_DEF) * 64'(ms)) / 64'(MS_PER_S);
      if (ticks == 0) begin
         return 64'(FULL_Q31);
      end
      st = span / ticks;
      if (st == 0 && span != 0) begin
         st = 1;
      end
      return st;
   endfunction

   // Advance one voice by one tick; returns the Q1.23 level
   function automatic logic [OUT_LVL_W-1:0] advance_envelope(
         input logic [VOICE_W-1:0] v, input logic g);
      logic [63:0] sus;
      logic [63:0] lvl;
      sus = 64'((sustain_q > SUS_MAX) ? SUS_MAX : sustain_q) << 8;
      // gate edges start attack or release
      if (g && !key_down[v]) begin
         key_down[v]  = 1'b1;
         env_phase[v] = PH_ATTACK;
         climb_step   = LVL_W'(ramp_step(64'(FULL_Q31), attack_ms_q));
         drop_step    = LVL_W'(ramp_step(64'(FULL_Q31) - sus, decay_ms_q));
      end
      if (!g && key_down[v]) begin
         key_down[v]  = 1'b0;
         env_phase[v] = PH_RELEASE;
         fade_step[v] = LVL_W'(ramp_step(64'(env_level[v]), release_ms_q));
      end
      lvl = 64'(env_level[v]);
      case (env_phase[v])
         PH_ATTACK: begin
            lvl = lvl + 64'(climb_step);
            if (lvl >= 64'(FULL_Q31)) begin
               lvl          = 64'(FULL_Q31);
               env_phase[v] = PH_DECAY;
            end
         end
         PH_DECAY: begin
            if (lvl <= sus + 64'(drop_step)) begin
               lvl          = sus;
               env_phase[v] = PH_SUSTAIN;
            end else begin
               lvl = lvl - 64'(drop_step);
            end
         end
         PH_SUSTAIN: begin
            lvl = sus;
         end
         PH_RELEASE: begin
            if (lvl <= 64'(fade_step[v])) begin
               lvl          = 0;
               env_phase[v] = PH_IDLE;
            end else begin
               lvl = lvl - 64'(fade_step[v]);
            end
         end
         PH_IDLE: begin
            lvl = 0;
         end
         default: ;
      endcase
      env_level[v] = lvl[LVL_W-1:0];
      return lvl[31:8];
   endfunction

   // Directed table row builders
   function automatic plan_row_type tick(input logic [VOICE_W-1:0] v, input logic g);
      plan_row_type row;
      row       = '0;
      row.voice = v;
      row.gate  = g;
      return row;
   endfunction

   function automatic plan_row_type tick_is(input logic [VOICE_W-1:0] v, input logic g,
                                            input logic [OUT_LVL_W-1:0] lvl);
      plan_row_type row;
      row       = tick(v, g);
      row.typed = 1'b1;
      row.level = lvl;
      return row;
   endfunction

   function automatic plan_row_type reg_write(input csr_index_type idx,
                                              input logic [CSR_DATA_W-1:0] val);
      plan_row_type row;
      row        = '0;
      row.is_csr = 1'b1;
      row.idx    = idx;
      row.value  = val;
      return row;
   endfunction

   // Duration pick: mostly short so envelopes complete, sometimes extreme
   function automatic logic [MS_W-1:0] pick_ms();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 15) return '0;
      if (r < 22) return '1;
      if (r < 30) return MS_W'($urandom_range(0, 65535));
      return MS_W'($urandom_range(1, 3));
   endfunction

   // Present one tick request and book its expected level on acceptance
   task automatic push_request(input logic [VOICE_W-1:0] v, input logic g,
                               input logic typed, input logic [OUT_LVL_W-1:0] typed_level);
      envelope_sample_type want;
      logic [OUT_LVL_W-1:0] lvl;
      @(negedge clock);
      while (!quiet && $urandom_range(0, 99) < STALL_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, g, v};
      do @(posedge clock); while (!req_tready);
      lvl        = advance_envelope(v, g);
      want.voice = v;
      want.level = typed ? typed_level : lvl;
      pending_levels.push_back(want);
   endtask

   // Stop sending and wait until every booked level has come back
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_levels.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Single register write; the predictor takes it at the same edge
   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_ATTACK:  attack_ms_q  = val[MS_W-1:0];
         CSR_DECAY:   decay_ms_q   = val[MS_W-1:0];
         CSR_SUSTAIN: sustain_q    = val[SUS_W-1:0];
         CSR_RELEASE: release_ms_q = val[MS_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic report_mismatch(input string what, input logic [OUT_LVL_W-1:0] want,
                                  input logic [OUT_LVL_W-1:0] got);
      if (mismatches < 10) begin
         $display("mismatch in %s: expected %h, got %h", what, want, got);
      end
      mismatches++;
   endtask

   // Response side: random back-pressure, set at the falling edge
   always @(negedge clock) begin
      rsp_tready <= quiet || ($urandom_range(0, 99) >= STALL_PCT);
   end

   // Response check against the oldest booked level, plus the watchdog
   always @(posedge clock) begin
      envelope_sample_type want;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_levels.size() == 0) begin
               report_mismatch("unexpected response", '0, rsp_tdata[27:4]);
            end else begin
               want = pending_levels.pop_front();
               if (rsp_tdata[3:0] != want.voice) begin
                  report_mismatch("out_voice", OUT_LVL_W'(want.voice),
                                  OUT_LVL_W'(rsp_tdata[3:0]));
               end
               if (rsp_tdata[27:4] != want.level) begin
                  report_mismatch("level", want.level, rsp_tdata[27:4]);
               end
            end
         end
      end
   end

   // Main sequence
   initial begin
      int unsigned r;
      logic [VOICE_W-1:0] v, hot_a, hot_b;
      logic g;
      logic [SUS_W-1:0] sus;

      attack_ms_q  = '0;
      decay_ms_q   = '0;
      sustain_q    = '0;
      release_ms_q = '0;
      climb_step   = '0;
      drop_step    = '0;
      for (int i = 0; i < N_VOICES; i++) begin
         env_level[i] = '0;
         env_phase[i] = PH_IDLE;
         key_down[i]  = 1'b0;
         fade_step[i] = '0;
         gate_plan[i] = 1'b0;
         gate_left[i] = $urandom_range(1, 8);
      end

      plan_rows = '{
         tick_is(4'd0, 1'b0, 24'h000000),       // idle voice after reset
         tick_is(4'd15, 1'b1, 24'h800000),      // instant attack
         tick_is(4'd15, 1'b1, 24'h000000),      // instant decay to zero sustain
         tick_is(4'd15, 1'b0, 24'h000000),      // release from zero
         reg_write(CSR_SUSTAIN, 24'd8388608),
         tick_is(4'd3, 1'b1, 24'h800000),
         tick_is(4'd3, 1'b1, 24'h800000),       // decay with nothing to cover
         reg_write(CSR_SUSTAIN, 24'hFFFFFF),
         tick_is(4'd3, 1'b1, 24'h800000),       // oversized sustain clamps
         reg_write(CSR_RELEASE, 24'h00FFFF),
         tick(4'd3, 1'b0),                      // longest release
         tick(4'd3, 1'b0),
         reg_write(CSR_ATTACK, 24'h00FFFF),
         tick(4'd5, 1'b1),                      // longest attack
         tick(4'd5, 1'b0),                      // release step rounds up to one
         tick(4'd5, 1'b0),
         reg_write(CSR_DECAY, 24'h00FFFF),
         reg_write(CSR_SUSTAIN, 24'd8388607),
         reg_write(CSR_ATTACK, 24'h000000),
         tick_is(4'd10, 1'b1, 24'h800000),
         tick(4'd10, 1'b1),                     // decay step rounds up to one
         tick(4'd10, 1'b1),
         reg_write(CSR_ATTACK, 24'h000001),
         reg_write(CSR_DECAY, 24'h000001),
         reg_write(CSR_SUSTAIN, 24'h400000),
         reg_write(CSR_RELEASE, 24'h000001),
         tick(4'd12, 1'b1),
         tick(4'd12, 1'b1),
         tick(4'd12, 1'b0),
         tick(4'd12, 1'b1),                     // retrigger during release
         tick(4'd12, 1'b1)
      };

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed table
      foreach (plan_rows[i]) begin
         if (plan_rows[i].is_csr) begin
            wait_drained();
            write_csr(plan_rows[i].idx, plan_rows[i].value);
         end else begin
            push_request(plan_rows[i].voice, plan_rows[i].gate,
                         plan_rows[i].typed, plan_rows[i].level);
         end
      end

      // Random phases, each with fresh register values
      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         quiet = (p == 2);
         r = $urandom_range(0, 99);
         if (r < 15) sus = '0;
         else if (r < 30) sus = SUS_MAX;
         else if (r < 35) sus = '1;
         else sus = SUS_W'($urandom_range(0, SUS_MAX));
         if (p == 1) begin
            write_csr(CSR_ATTACK, 24'h000000);
            write_csr(CSR_DECAY, 24'h00FFFF);
            write_csr(CSR_SUSTAIN, 24'h000000);
            write_csr(CSR_RELEASE, 24'h00FFFF);
         end else if (p == 4) begin
            write_csr(CSR_ATTACK, 24'h00FFFF);
            write_csr(CSR_DECAY, 24'h000000);
            write_csr(CSR_SUSTAIN, 24'hFFFFFF);
            write_csr(CSR_RELEASE, 24'h000000);
         end else begin
            write_csr(CSR_ATTACK, CSR_DATA_W'(pick_ms()));
            write_csr(CSR_DECAY, CSR_DATA_W'(pick_ms()));
            write_csr(CSR_SUSTAIN, sus);
            write_csr(CSR_RELEASE, CSR_DATA_W'(pick_ms()));
         end
         hot_a = VOICE_W'($urandom_range(0, N_VOICES - 1));
         hot_b = VOICE_W'($urandom_range(0, N_VOICES - 1));
         for (int k = 0; k < TICKS_PER_PASS; k++) begin
            r = $urandom_range(0, 99);
            v = (r < 40) ? hot_a : (r < 80) ? hot_b : VOICE_W'($urandom_range(0, N_VOICES - 1));
            if ($urandom_range(0, 99) < 8) begin
               // noise: gate flips off the plan
               g = 1'($urandom_range(0, 1));
            end else begin
               g = gate_plan[v];
               if (gate_left[v] <= 1) begin
                  gate_plan[v] = ~gate_plan[v];
                  gate_left[v] = gate_plan[v] ? $urandom_range(1, 120) : $urandom_range(1, 60);
               end else begin
                  gate_left[v]--;
               end
            end
            push_request(v, g, 1'b0, '0);
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_levels.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
